>>> rtl/slbc_pkg.sv
// Shared types, constants and the button debounce step for the sensor level
// and button conditioner. No dependencies.
`default_nettype none

package slbc_pkg;

   // Geometry and fixed field widths
   localparam int unsigned RING_DEPTH_DEF = 64;
   localparam int unsigned SAMPLE_W       = 12;
   localparam int unsigned LEVEL_W        = 4;
   localparam int unsigned TICK_W         = 8;
   localparam int unsigned CSR_ADDR_W     = 3;
   localparam int unsigned CSR_DATA_W     = 32;
   localparam int unsigned MEAN_STEP      = 512;   // mean bits 9..11 select the band

   // Register map: index taken from paddr[2]
   localparam logic REG_CONFIRM  = 1'b0;
   localparam logic REG_DEBOUNCE = 1'b1;

   localparam logic [TICK_W-1:0]  CONFIRM_RST  = 8'd100;
   localparam logic [TICK_W-1:0]  DEBOUNCE_RST = 8'd10;
   localparam logic [LEVEL_W-1:0] LEVEL_MIN    = 4'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 4'd8;

   typedef struct packed {
      logic               sensor_report;
      logic [LEVEL_W-1:0] sensor_level;
      logic               button_a_stable;
      logic               button_b_stable;
      logic               manual_report_a;
      logic [LEVEL_W-1:0] manual_level_a;
      logic               manual_report_b;
      logic [LEVEL_W-1:0] manual_level_b;
   } result_type;

   typedef struct packed {
      logic              state;
      logic [TICK_W-1:0] count;
      logic              released;
   } debounce_type;

   // One tick of a button debouncer. The count only moves while the raw bit
   // differs from the debounced state and is cleared only when the state flips.
   function automatic debounce_type debounce_step(input logic raw,
                                                  input logic state,
                                                  input logic [TICK_W-1:0] count,
                                                  input logic [TICK_W-1:0] ticks);
      debounce_type      r;
      logic [TICK_W-1:0] cnt_inc;
      cnt_inc    = count + 8'd1;
      r.state    = state;
      r.count    = count;
      r.released = 1'b0;
      if (raw != state) begin
         if (cnt_inc > ticks) begin
            r.count    = '0;
            r.state    = raw;
            r.released = ~raw;
         end else begin
            r.count = cnt_inc;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/slbc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module slbc_ram #(
   parameter int unsigned WIDTH = 12,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/sensor_level_and_button_conditioner.sv
// Top level of the sensor level and button conditioner: boxcar average over
// a sample ring in RAM, level adoption, button debounce and manual level.
// Depends on slbc_pkg and slbc_ram.
`default_nettype none

// Channel   Direction  Handshake            Word
// --------  ---------  -------------------  --------------------------------------
// req_      in         req_valid/req_stall  adc_sample, button_a_raw, button_b_raw
// rsp_      out        rsp_valid/rsp_stall  sensor/button/manual level result
// csr       in/out     APB (pready = 1)     confirm_ticks @0, debounce_ticks @4
//
// One word per cycle sustained while rsp_stall stays low; a word's result is
// registered when it is accepted. The oldest ring sample is prefetched from
// the RAM (the ring position is known), so the RAM's single read port is what
// sets the rate. Reset is synchronous; after it the ring reads as zero until
// the write pointer has gone round once (a single fill flag, no clearing pass).
// A two-word output buffer takes a new word while the result ahead of it is
// still stalled; req_stall rises only when both places are full.

module sensor_level_and_button_conditioner #(
   parameter int unsigned RING_DEPTH = slbc_pkg::RING_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input words
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [slbc_pkg::SAMPLE_W-1:0]       req_adc_sample,
   input  wire logic                                req_button_a_raw,
   input  wire logic                                req_button_b_raw,
   // result words
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic                                rsp_sensor_report,
   output      logic [slbc_pkg::LEVEL_W-1:0]        rsp_sensor_level,
   output      logic                                rsp_button_a_stable,
   output      logic                                rsp_button_b_stable,
   output      logic                                rsp_manual_report_a,
   output      logic [slbc_pkg::LEVEL_W-1:0]        rsp_manual_level_a,
   output      logic                                rsp_manual_report_b,
   output      logic [slbc_pkg::LEVEL_W-1:0]        rsp_manual_level_b,
   // configuration
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [slbc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [slbc_pkg::CSR_DATA_W-1:0]     pwdata,
   output      logic [slbc_pkg::CSR_DATA_W-1:0]     prdata,
   output      logic                                pready
);

   import slbc_pkg::*;

   localparam int unsigned ADDR_W = $clog2(RING_DEPTH);
   // Largest sum is RING_DEPTH full-scale samples
   localparam int unsigned SUM_W  = $clog2(RING_DEPTH * 4095 + 1);
   localparam logic [ADDR_W-1:0] POS_LAST = ADDR_W'(RING_DEPTH - 1);

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic [TICK_W-1:0] confirm_ff, debounce_ff;
   logic              csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         confirm_ff  <= CONFIRM_RST;
         debounce_ff <= DEBOUNCE_RST;
      end else if (csr_wr) begin
         case (paddr[2])
            REG_CONFIRM:  confirm_ff  <= pwdata[TICK_W-1:0];
            REG_DEBOUNCE: debounce_ff <= pwdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_CONFIRM:  prdata = {{(CSR_DATA_W-TICK_W){1'b0}}, confirm_ff};
         REG_DEBOUNCE: prdata = {{(CSR_DATA_W-TICK_W){1'b0}}, debounce_ff};
         default:      prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Handshakes and output buffer control
   // ---------------------------------------------------------------------------
   logic       out_valid_ff, skid_valid_ff;
   result_type out_ff, skid_ff, result;
   logic       accept, pop;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~skid_valid_ff;
   assign pop       = out_valid_ff & ~rsp_stall;

   // ---------------------------------------------------------------------------
   // Sample ring: write the new sample at pos_ff, prefetch the next slot.
   // Read and write never hit the same entry in one cycle (depth >= 2).
   // ---------------------------------------------------------------------------
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   logic                filled_ff, filled_in;
   logic [SAMPLE_W-1:0] ring_rd, oldest;
   logic [SUM_W-1:0]    sum_ff, sum_in;

   always_comb begin
      pos_in    = pos_ff;
      filled_in = filled_ff;
      if (accept) begin
         if (pos_ff == POS_LAST) begin
            pos_in    = '0;
            filled_in = 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   slbc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (pos_ff),
      .wr_data (req_adc_sample),
      .rd_addr (pos_in),
      .rd_data (ring_rd)
   );

   // Before the first wrap every slot read is one never written: zero.
   assign oldest = filled_ff ? ring_rd : '0;
   assign sum_in = sum_ff - SUM_W'(oldest) + SUM_W'(req_adc_sample);

   // Level band: floor(sum / (512 * depth)), 0..7, by constant thresholds
   logic [2:0]         band;
   logic [LEVEL_W-1:0] cand_level;

   always_comb begin
      band = '0;
      for (int k = 1; k < 8; k++) begin
         if (sum_in >= SUM_W'(k * MEAN_STEP * RING_DEPTH)) begin
            band = band + 3'd1;
         end
      end
      cand_level = LEVEL_MAX - {1'b0, band};
   end

   // ---------------------------------------------------------------------------
   // Level adoption. Persist count is kept on adoption, cleared on a match.
   // ---------------------------------------------------------------------------
   logic [LEVEL_W-1:0] adopted_ff, adopted_in;
   logic [TICK_W-1:0]  persist_ff, persist_in;
   logic               sensor_rep;

   always_comb begin
      adopted_in = adopted_ff;
      persist_in = persist_ff;
      sensor_rep = 1'b0;
      if (cand_level != adopted_ff) begin
         if (persist_ff < confirm_ff) begin
            persist_in = persist_ff + 8'd1;
         end else begin
            adopted_in = cand_level;
            sensor_rep = 1'b1;
         end
      end else begin
         persist_in = '0;
      end
   end

   // ---------------------------------------------------------------------------
   // Buttons and manual level. Button A is handled before button B.
   // ---------------------------------------------------------------------------
   logic              btn_a_ff, btn_b_ff;
   logic [TICK_W-1:0] cnt_a_ff, cnt_b_ff;
   logic [LEVEL_W-1:0] manual_ff, manual_in, lvl_a;
   logic               rev_ff, rev_in;
   debounce_type       db_a, db_b;

   assign db_a = debounce_step(req_button_a_raw, btn_a_ff, cnt_a_ff, debounce_ff);
   assign db_b = debounce_step(req_button_b_raw, btn_b_ff, cnt_b_ff, debounce_ff);

   always_comb begin
      manual_in = manual_ff;
      rev_in    = rev_ff;
      // A: down until 1 then reverse; reversed goes up until 8 then back
      if (db_a.released) begin
         if (!rev_in) begin
            if (manual_in <= LEVEL_MIN) begin
               manual_in = LEVEL_MIN;
               rev_in    = 1'b1;
            end else begin
               manual_in = manual_in - 4'd1;
            end
         end else begin
            if (manual_in >= LEVEL_MAX) begin
               manual_in = LEVEL_MAX;
               rev_in    = 1'b0;
            end else begin
               manual_in = manual_in + 4'd1;
            end
         end
      end
      lvl_a = manual_in;
      // B: up and saturate at 8; reversed goes down and sets reverse at 1
      if (db_b.released) begin
         if (!rev_in) begin
            if (manual_in < LEVEL_MAX) begin
               manual_in = manual_in + 4'd1;
            end else begin
               manual_in = LEVEL_MAX;
            end
         end else begin
            if (manual_in <= LEVEL_MIN) begin
               manual_in = LEVEL_MIN;
               rev_in    = 1'b1;
            end else begin
               manual_in = manual_in - 4'd1;
            end
         end
      end
   end

   always_comb begin
      result.sensor_report   = sensor_rep;
      result.sensor_level    = adopted_in;
      result.button_a_stable = db_a.state;
      result.button_b_stable = db_b.state;
      result.manual_report_a = db_a.released;
      result.manual_level_a  = lvl_a;
      result.manual_report_b = db_b.released;
      result.manual_level_b  = manual_in;
   end

   // ---------------------------------------------------------------------------
   // State registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         filled_ff  <= 1'b0;
         sum_ff     <= '0;
         adopted_ff <= LEVEL_MIN;
         persist_ff <= '0;
         btn_a_ff   <= 1'b0;
         cnt_a_ff   <= '0;
         btn_b_ff   <= 1'b0;
         cnt_b_ff   <= '0;
         manual_ff  <= LEVEL_MIN;
         rev_ff     <= 1'b0;
      end else if (accept) begin
         pos_ff     <= pos_in;
         filled_ff  <= filled_in;
         sum_ff     <= sum_in;
         adopted_ff <= adopted_in;
         persist_ff <= persist_in;
         btn_a_ff   <= db_a.state;
         cnt_a_ff   <= db_a.count;
         btn_b_ff   <= db_b.state;
         cnt_b_ff   <= db_b.count;
         manual_ff  <= manual_in;
         rev_ff     <= rev_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Output buffer: head register plus one skid word
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_sensor_report   = out_ff.sensor_report;
   assign rsp_sensor_level    = out_ff.sensor_level;
   assign rsp_button_a_stable = out_ff.button_a_stable;
   assign rsp_button_b_stable = out_ff.button_b_stable;
   assign rsp_manual_report_a = out_ff.manual_report_a;
   assign rsp_manual_level_a  = out_ff.manual_level_a;
   assign rsp_manual_report_b = out_ff.manual_report_b;
   assign rsp_manual_level_b  = out_ff.manual_level_b;

endmodule

`default_nettype wire

>>> bench/sensor_level_and_button_conditioner_test.sv
// Self-checking bench for sensor_level_and_button_conditioner: boxcar level, debounce and
// manual-level results are predicted word by word and compared field by field.
// Depends on slbc_pkg and the block's RTL only.
`timescale 1ns / 1ps

module sensor_level_and_button_conditioner_test;
   import slbc_pkg::*;

   localparam int unsigned RING = RING_DEPTH_DEF;
   localparam logic [CSR_ADDR_W-1:0] ADDR_CONFIRM  = {REG_CONFIRM, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_DEBOUNCE = {REG_DEBOUNCE, 2'b00};

   // Level/button predictor plus the queue of results still owed by the block.
   class level_scoreboard;
      bit [SAMPLE_W-1:0] ring [RING];
      bit [17:0]         sum;
      bit [5:0]          slot;
      bit [LEVEL_W-1:0]  adopted;
      bit [TICK_W-1:0]   persist;
      bit                state_a, state_b;
      bit [TICK_W-1:0]   count_a, count_b;
      bit [LEVEL_W-1:0]  manual;
      bit                reversed;
      bit [TICK_W-1:0]   confirm_ticks, debounce_ticks;
      result_type        owed_q[$];
      int                failures, checked, adoptions, releases;

      function new();
         foreach (ring[i]) ring[i] = '0;
         sum            = '0;
         slot           = '0;
         adopted        = LEVEL_MIN;
         persist        = '0;
         state_a        = 1'b0;
         state_b        = 1'b0;
         count_a        = '0;
         count_b        = '0;
         manual         = LEVEL_MIN;
         reversed       = 1'b0;
         confirm_ticks  = CONFIRM_RST;
         debounce_ticks = DEBOUNCE_RST;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      function void set_reg(logic [CSR_ADDR_W-1:0] addr, logic [TICK_W-1:0] value);
         if (addr[2] == REG_CONFIRM) confirm_ticks = value;
         else debounce_ticks = value;
      endfunction

      task report_miss(string what);
         failures++;
         $display("MISMATCH at result %0d: %s", checked, what);
      endtask

      // Count runs only while raw differs; 8-bit wrap means 255 never flips.
      function bit debounce_button(bit raw, inout bit state, inout bit [TICK_W-1:0] count);
         if (raw != state) begin
            count = count + 1'b1;
            if (count > debounce_ticks) begin
               count = '0;
               state = raw;
               return !raw;
            end
         end
         return 1'b0;
      endfunction

      function void manual_down();
         if (manual <= LEVEL_MIN) begin
            manual   = LEVEL_MIN;
            reversed = 1'b1;
         end else begin
            manual = manual - 1'b1;
         end
      endfunction

      function void note_word(bit [SAMPLE_W-1:0] sample, bit raw_a, bit raw_b);
         result_type       r;
         bit [11:0]        mean;
         bit [LEVEL_W-1:0] cand;
         r = '0;
         sum        = sum - ring[slot] + sample;
         ring[slot] = sample;
         slot       = slot + 1'b1;
         mean       = sum[17:6];
         cand       = LEVEL_MAX - mean[11:9];
         // persist count survives adoption; only a matching tick clears it
         if (cand != adopted) begin
            if (persist < confirm_ticks) begin
               persist = persist + 1'b1;
            end else begin
               adopted         = cand;
               r.sensor_report = 1'b1;
               adoptions++;
            end
         end else begin
            persist = '0;
         end
         // first button: down, or up once reversed (top end clears reverse)
         r.manual_report_a = debounce_button(raw_a, state_a, count_a);
         if (r.manual_report_a) begin
            releases++;
            if (!reversed) manual_down();
            else if (manual >= LEVEL_MAX) begin
               manual   = LEVEL_MAX;
               reversed = 1'b0;
            end else manual = manual + 1'b1;
         end
         r.manual_level_a = manual;
         // second button: up and saturate, or down once reversed
         r.manual_report_b = debounce_button(raw_b, state_b, count_b);
         if (r.manual_report_b) begin
            releases++;
            if (reversed) manual_down();
            else if (manual < LEVEL_MAX) manual = manual + 1'b1;
            else manual = LEVEL_MAX;
         end
         r.manual_level_b  = manual;
         r.sensor_level    = adopted;
         r.button_a_stable = state_a;
         r.button_b_stable = state_b;
         owed_q.push_back(r);
      endfunction

      task check_field(string name, logic [LEVEL_W-1:0] want, logic [LEVEL_W-1:0] got);
         if (got !== want) report_miss($sformatf("%s got %0h want %0h", name, got, want));
      endtask

      task check_word(result_type got);
         result_type want;
         checked++;
         if (owed_q.size() == 0) begin
            report_miss("result word with nothing expected");
            return;
         end
         want = owed_q.pop_front();
         check_field("sensor_report", want.sensor_report, got.sensor_report);
         check_field("sensor_level", want.sensor_level, got.sensor_level);
         check_field("button_a_stable", want.button_a_stable, got.button_a_stable);
         check_field("button_b_stable", want.button_b_stable, got.button_b_stable);
         check_field("manual_report_a", want.manual_report_a, got.manual_report_a);
         check_field("manual_level_a", want.manual_level_a, got.manual_level_a);
         check_field("manual_report_b", want.manual_report_b, got.manual_report_b);
         check_field("manual_level_b", want.manual_level_b, got.manual_level_b);
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [SAMPLE_W-1:0]   req_adc_sample;
   logic                  req_button_a_raw;
   logic                  req_button_b_raw;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_sensor_report;
   logic [LEVEL_W-1:0]    rsp_sensor_level;
   logic                  rsp_button_a_stable;
   logic                  rsp_button_b_stable;
   logic                  rsp_manual_report_a;
   logic [LEVEL_W-1:0]    rsp_manual_level_a;
   logic                  rsp_manual_report_b;
   logic [LEVEL_W-1:0]    rsp_manual_level_b;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   level_scoreboard book = new();

   int words_sent    = 0;
   int settings_used = 0;
   int hold_request  = 0;    // long receiver hold-off, picked up by the result side
   bit send_steady   = 1'b0; // sender offers words back to back
   bit recv_steady   = 1'b0; // receiver never stalls

   sensor_level_and_button_conditioner dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_adc_sample      (req_adc_sample),
      .req_button_a_raw    (req_button_a_raw),
      .req_button_b_raw    (req_button_b_raw),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_sensor_report   (rsp_sensor_report),
      .rsp_sensor_level    (rsp_sensor_level),
      .rsp_button_a_stable (rsp_button_a_stable),
      .rsp_button_b_stable (rsp_button_b_stable),
      .rsp_manual_report_a (rsp_manual_report_a),
      .rsp_manual_level_a  (rsp_manual_level_a),
      .rsp_manual_report_b (rsp_manual_report_b),
      .rsp_manual_level_b  (rsp_manual_level_b),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Hard stop in case a handshake never completes.
   initial begin
      #1_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Offer one word at the falling edge after a random gap and hold it until taken.
   // Called and returning at a falling edge; valid stays high for a back-to-back word.
   task automatic send_word(logic [SAMPLE_W-1:0] sample, logic raw_a, logic raw_b);
      int gap;
      gap = send_steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_adc_sample   <= sample;
      req_button_a_raw <= raw_a;
      req_button_b_raw <= raw_b;
      do @(posedge clock); while (req_stall);
      book.note_word(sample, raw_a, raw_b);
      words_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every owed result word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // APB write (setup + access), then read back the same register.
   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [TICK_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      book.set_reg(addr, value);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback !== CSR_DATA_W'(value))
         book.report_miss($sformatf("register @%0d read %0h want %0h", addr, readback, value));
   endtask

   // One setting of both registers, then words in segments: each segment sits near one
   // mean band with the buttons mostly held (with bounce), some segments are pure noise.
   task automatic run_phase(int confirm, int debounce, int words, int seg_max, int noise_pct);
      int   sent;
      int   seg_len;
      int   center;
      int   v;
      bit   noisy;
      logic hold_a, hold_b;
      logic [SAMPLE_W-1:0] sample;
      logic raw_a, raw_b;
      drain();
      csr_write(ADDR_CONFIRM, TICK_W'(confirm));
      csr_write(ADDR_DEBOUNCE, TICK_W'(debounce));
      settings_used++;
      sent = 0;
      while (sent < words) begin
         seg_len = $urandom_range(1, seg_max);
         center  = $urandom_range(0, 4095);
         hold_a  = 1'($urandom_range(0, 1));
         hold_b  = 1'($urandom_range(0, 1));
         noisy   = ($urandom_range(0, 99) < noise_pct);
         for (int k = 0; k < seg_len && sent < words; k++) begin
            if (noisy || $urandom_range(0, 15) == 0) begin
               sample = SAMPLE_W'($urandom_range(0, 4095));
               raw_a  = 1'($urandom_range(0, 1));
               raw_b  = 1'($urandom_range(0, 1));
            end else begin
               v = center + $urandom_range(0, 64) - 32;
               if (v < 0) v = 0;
               if (v > 4095) v = 4095;
               sample = SAMPLE_W'(v);
               raw_a  = ($urandom_range(0, 7) == 0) ? ~hold_a : hold_a;
               raw_b  = ($urandom_range(0, 7) == 0) ? ~hold_b : hold_b;
            end
            send_word(sample, raw_a, raw_b);
            sent++;
         end
      end
   endtask

   // Result side: random stall per word, or one long hold-off when asked for.
   initial begin : result_side
      int         hold;
      result_type got;
      rsp_stall = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (hold_request > 0) begin
            hold         = hold_request;
            hold_request = 0;
         end else begin
            hold = recv_steady ? 0 : $urandom_range(0, 8);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         got = {rsp_sensor_report, rsp_sensor_level, rsp_button_a_stable,
                rsp_button_b_stable, rsp_manual_report_a, rsp_manual_level_a,
                rsp_manual_report_b, rsp_manual_level_b};
         book.check_word(got);
         @(negedge clock);
      end
   end

   // Main sequence
   initial begin : stimulus
      logic [SAMPLE_W-1:0] edge_samples [4];
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_adc_sample   = '0;
      req_button_a_raw = 1'b0;
      req_button_b_raw = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      edge_samples     = '{12'h000, 12'hAAA, 12'h555, 12'hFFF};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // a couple of words at the reset settings
      send_word(12'h000, 1'b0, 1'b0);
      send_word(12'hFFF, 1'b1, 1'b1);

      // directed: zero confirm and debounce, so every level change is adopted at once
      // and each raw toggle flips a button; full-scale samples push the mean up,
      // and both buttons get released together (first button handled first)
      drain();
      csr_write(ADDR_CONFIRM, TICK_W'(0));
      csr_write(ADDR_DEBOUNCE, TICK_W'(0));
      settings_used++;
      for (int i = 0; i < 20; i++)
         send_word(i < 14 ? 12'hFFF : edge_samples[i % 4], i[0], i[1]);

      // random part over several settings, extremes included
      run_phase(0, 0, 200, 40, 10);

      // receiver holds off while the sender keeps offering: output buffer fills
      hold_request = 60;
      send_steady  = 1'b1;
      run_phase(5, 3, 120, 40, 0);
      send_steady  = 1'b0;
      run_phase(5, 3, 180, 40, 15);

      run_phase(255, 254, 150, 120, 0);

      // a stretch with no idling on either side
      send_steady = 1'b1;
      recv_steady = 1'b1;
      run_phase(2, 1, 300, 40, 10);
      send_steady = 1'b0;
      recv_steady = 1'b0;

      // debounce at 255: the count wraps and the buttons never flip
      run_phase(20, 255, 100, 40, 100);

      // the phase start waits for every owed result, so this is a full sender pause
      run_phase(1, 6, 240, 40, 20);
      run_phase(1, 6, 240, 40, 20);

      drain();
      repeat (8) @(posedge clock);
      if (book.pending() != 0)
         book.report_miss($sformatf("%0d result words never arrived", book.pending()));

      $display("Run: %0d words under %0d register settings, %0d results compared",
               words_sent, settings_used, book.checked);
      $display("     %0d level adoptions and %0d button releases predicted, %0d mismatches",
               book.adoptions, book.releases, book.failures);
      if (book.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
